@@ design/bol_pkg.sv @@
`timescale 1ns / 1ps

package bol_pkg;

   localparam int OP_W     = 3;
   localparam int VAL_W    = 8;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 3;
   localparam int SIZE_W   = 6;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [VAL_W-1:0]    val_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SIZE_W-1:0]   size_type;

   localparam op_type OP_ADD_BACK   = 3'd0;
   localparam op_type OP_ADD_FRONT  = 3'd1;
   localparam op_type OP_TAKE_FRONT = 3'd2;
   localparam op_type OP_TAKE_BACK  = 3'd3;
   localparam op_type OP_INSERT     = 3'd4;
   localparam op_type OP_DEL_VALUE  = 3'd5;
   localparam op_type OP_DEL_POS    = 3'd6;
   localparam op_type OP_READ       = 3'd7;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_EMPTY    = 3'd1;
   localparam status_type ST_BADPOS   = 3'd2;
   localparam status_type ST_NOTFOUND = 3'd3;
   localparam status_type ST_FULL     = 3'd4;

endpackage

@@ design/bol_req_if.sv @@
`timescale 1ns / 1ps

interface bol_req_if;
   logic             valid;
   logic             ready;
   bol_pkg::op_type  op;
   bol_pkg::val_type value;
   bol_pkg::pos_type position;

   modport source (output valid, output op, output value, output position, input ready);
   modport sink (input valid, input op, input value, input position, output ready);
endinterface

@@ design/bol_rsp_if.sv @@
`timescale 1ns / 1ps

interface bol_rsp_if;
   logic                valid;
   logic                ready;
   bol_pkg::status_type status;
   bol_pkg::val_type    read_value;
   bol_pkg::val_type    head_value;
   bol_pkg::val_type    tail_value;
   bol_pkg::size_type   size;

   modport source (output valid, output status, output read_value, output head_value,
                   output tail_value, output size, input ready);
   modport sink (input valid, input status, input read_value, input head_value,
                 input tail_value, input size, output ready);
endinterface

@@ design/bounded_ordered_list.sv @@
`timescale 1ns / 1ps

// Bounded ordered list of up to ENTRIES value ids, held in order in a single-port-write,
// single-port-read memory and worked on by a small sequencer that moves one entry at a
// time. A request is taken only while the block is idle, and exactly one result transfer
// follows each request. Push back, pop back, insert into an empty list and failed
// requests go straight to the final reads, and a read first captures the addressed entry.
// Push front, insert, pop front and delete by position shift entries one at a time, with
// a read and a write for each entry that is shifted. Delete by value reads and compares
// the entries in order until it finds a match and then closes the gap, or reports not
// found after every entry; the result is held until the receiver takes it. The memory
// has one read port with registered read data, and two final reads fetch the head and
// tail for the result.

module bounded_ordered_list #(
   parameter int ENTRIES = 32,
   parameter int VALUE_W = 8
) (
   input  logic       clock,
   input  logic       reset,
   bol_req_if.sink    req_bus,
   bol_rsp_if.source  rsp_bus
);

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int AW = $clog2(ENTRIES);
   localparam int XW = ((CW > bol_pkg::POS_W) ? CW : bol_pkg::POS_W) + 1;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_OPEN_RD  = 4'd1;
   localparam logic [3:0] S_OPEN_WR  = 4'd2;
   localparam logic [3:0] S_CLOSE_RD = 4'd3;
   localparam logic [3:0] S_CLOSE_WR = 4'd4;
   localparam logic [3:0] S_SRCH_RD  = 4'd5;
   localparam logic [3:0] S_SRCH_CMP = 4'd6;
   localparam logic [3:0] S_RD_CAP   = 4'd7;
   localparam logic [3:0] S_HEAD     = 4'd8;
   localparam logic [3:0] S_TAIL     = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;
   localparam logic [3:0] S_OUT      = 4'd11;

   logic [VALUE_W-1:0] entries_ff [ENTRIES];
   logic [VALUE_W-1:0] rdata_ff;

   logic [3:0]   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] at_ff, at_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   bol_pkg::status_type status_ff, status_in;
   bol_pkg::val_type rdv_ff, rdv_in;
   bol_pkg::val_type head_ff, head_in;
   bol_pkg::val_type tail_ff, tail_in;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;
   logic [AW-1:0]      mem_raddr;

   logic                     accept;
   logic [VALUE_W+7:0]       value_wide;
   logic [VALUE_W-1:0]       value_in;
   logic [VALUE_W+7:0]       rdata_wide;
   bol_pkg::val_type         rdata8;
   logic [XW-1:0]            pos_x;
   logic [XW-1:0]            cnt_x;
   logic [XW-1:0]            pos_inc;
   logic [XW-1:0]            pos_dec;
   logic [CW-1:0]            idx_inc;
   logic [CW-1:0]            idx_dec;
   logic [CW-1:0]            cnt_inc;
   logic [CW-1:0]            cnt_dec;
   logic [CW+5:0]            size_wide;
   logic                     full;
   logic                     empty;

   assign accept     = req_bus.valid && req_bus.ready;
   assign value_wide = {{VALUE_W{1'b0}}, req_bus.value};
   assign value_in   = value_wide[VALUE_W-1:0];
   assign rdata_wide = {8'b0, rdata_ff};
   assign rdata8     = rdata_wide[7:0];
   assign pos_x      = XW'(req_bus.position);
   assign cnt_x      = XW'(count_ff);
   assign pos_inc    = pos_x + XW'(1);
   assign pos_dec    = pos_x - XW'(1);
   assign idx_inc    = idx_ff + CW'(1);
   assign idx_dec    = idx_ff - CW'(1);
   assign cnt_inc    = count_ff + CW'(1);
   assign cnt_dec    = count_ff - CW'(1);
   assign full       = (count_ff == CW'(ENTRIES));
   assign empty      = (count_ff == '0);
   assign size_wide  = {6'b0, count_ff};

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = (state_ff == S_OUT);
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.read_value = rdv_ff;
   assign rsp_bus.head_value = head_ff;
   assign rsp_bus.tail_value = tail_ff;
   assign rsp_bus.size       = size_wide[5:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= entries_ff[mem_raddr];
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      at_in     = at_ff;
      val_in    = val_ff;
      status_in = status_ff;
      rdv_in    = rdv_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      mem_we    = 1'b0;
      mem_waddr = count_ff[AW-1:0];
      mem_wdata = value_in;
      mem_raddr = pos_x[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in    = value_in;
               status_in = bol_pkg::ST_OK;
               rdv_in    = '0;
               state_in  = S_HEAD;
               idx_in    = '0;
               case (req_bus.op)
                  bol_pkg::OP_ADD_BACK: begin
                     if (full) begin
                        status_in = bol_pkg::ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = cnt_inc;
                     end
                  end
                  bol_pkg::OP_ADD_FRONT: begin
                     if (full) begin
                        status_in = bol_pkg::ST_FULL;
                     end else begin
                        idx_in   = count_ff;
                        at_in    = '0;
                        state_in = S_OPEN_RD;
                     end
                  end
                  bol_pkg::OP_TAKE_FRONT: begin
                     if (empty) begin
                        status_in = bol_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_CLOSE_RD;
                     end
                  end
                  bol_pkg::OP_TAKE_BACK: begin
                     if (empty) begin
                        status_in = bol_pkg::ST_EMPTY;
                     end else begin
                        count_in = cnt_dec;
                     end
                  end
                  bol_pkg::OP_INSERT: begin
                     if (full) begin
                        status_in = bol_pkg::ST_FULL;
                     end else if (empty) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        count_in  = CW'(1);
                     end else if (pos_x >= cnt_x) begin
                        status_in = bol_pkg::ST_BADPOS;
                     end else begin
                        idx_in   = count_ff;
                        at_in    = pos_inc[CW-1:0];
                        state_in = S_OPEN_RD;
                     end
                  end
                  bol_pkg::OP_DEL_VALUE: begin
                     if (empty) begin
                        status_in = bol_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  bol_pkg::OP_DEL_POS: begin
                     if (empty) begin
                        status_in = bol_pkg::ST_EMPTY;
                     end else if ((pos_x == '0) || (pos_x > cnt_x)) begin
                        status_in = bol_pkg::ST_BADPOS;
                     end else begin
                        idx_in   = pos_dec[CW-1:0];
                        state_in = S_CLOSE_RD;
                     end
                  end
                  default: begin
                     if (empty) begin
                        status_in = bol_pkg::ST_EMPTY;
                     end else if (pos_x >= cnt_x) begin
                        status_in = bol_pkg::ST_BADPOS;
                     end else begin
                        state_in = S_RD_CAP;
                     end
                  end
               endcase
            end
         end
         S_OPEN_RD: begin
            if (idx_ff == at_ff) begin
               mem_we    = 1'b1;
               mem_waddr = at_ff[AW-1:0];
               mem_wdata = val_ff;
               count_in  = cnt_inc;
               state_in  = S_HEAD;
            end else begin
               mem_raddr = idx_dec[AW-1:0];
               state_in  = S_OPEN_WR;
            end
         end
         S_OPEN_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = rdata_ff;
            idx_in    = idx_dec;
            state_in  = S_OPEN_RD;
         end
         S_CLOSE_RD: begin
            if (idx_inc == count_ff) begin
               count_in = cnt_dec;
               state_in = S_HEAD;
            end else begin
               mem_raddr = idx_inc[AW-1:0];
               state_in  = S_CLOSE_WR;
            end
         end
         S_CLOSE_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = rdata_ff;
            idx_in    = idx_inc;
            state_in  = S_CLOSE_RD;
         end
         S_SRCH_RD: begin
            if (idx_ff == count_ff) begin
               status_in = bol_pkg::ST_NOTFOUND;
               state_in  = S_HEAD;
            end else begin
               mem_raddr = idx_ff[AW-1:0];
               state_in  = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (rdata_ff == val_ff) begin
               state_in = S_CLOSE_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = S_SRCH_RD;
            end
         end
         S_RD_CAP: begin
            rdv_in   = rdata8;
            state_in = S_HEAD;
         end
         S_HEAD: begin
            mem_raddr = '0;
            state_in  = S_TAIL;
         end
         S_TAIL: begin
            head_in   = empty ? '0 : rdata8;
            mem_raddr = cnt_dec[AW-1:0];
            state_in  = S_DONE;
         end
         S_DONE: begin
            tail_in  = empty ? '0 : rdata8;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      at_ff     <= at_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      rdv_ff    <= rdv_in;
      head_ff   <= head_in;
      tail_ff   <= tail_in;
   end

endmodule

@@ sim/list_result_checker.sv @@
`timescale 1ns / 1ps

module list_result_checker #(
   parameter int ENTRIES = 32
) (
   input  logic clock,
   input  logic reset,
   bol_req_if   req_mon,
   bol_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);

   typedef struct packed {
      bol_pkg::status_type status;
      bol_pkg::val_type    read_value;
      bol_pkg::val_type    head_value;
      bol_pkg::val_type    tail_value;
      bol_pkg::size_type   size;
   } list_result_type;

   bol_pkg::val_type list_entries [ENTRIES];
   int               list_count;
   list_result_type  expected_results [$];
   int               result_index;

   function automatic void open_gap(input int at);
      for (int k = list_count; k > at; k--) begin
         list_entries[k] = list_entries[k-1];
      end
      list_count++;
   endfunction

   function automatic void close_gap(input int at);
      for (int k = at; k + 1 < list_count; k++) begin
         list_entries[k] = list_entries[k+1];
      end
      list_count--;
   endfunction

   function automatic list_result_type apply_request(input bol_pkg::op_type op,
                                                     input bol_pkg::val_type value,
                                                     input bol_pkg::pos_type pos);
      list_result_type res;
      int              hit;
      res        = '0;
      res.status = bol_pkg::ST_OK;
      hit        = -1;
      case (op)
         bol_pkg::OP_ADD_BACK, bol_pkg::OP_ADD_FRONT: begin
            if (list_count >= ENTRIES) begin
               res.status = bol_pkg::ST_FULL;
            end else if (op == bol_pkg::OP_ADD_BACK) begin
               list_entries[list_count] = value;
               list_count++;
            end else begin
               open_gap(0);
               list_entries[0] = value;
            end
         end
         bol_pkg::OP_TAKE_FRONT, bol_pkg::OP_TAKE_BACK: begin
            if (list_count == 0) begin
               res.status = bol_pkg::ST_EMPTY;
            end else if (op == bol_pkg::OP_TAKE_FRONT) begin
               close_gap(0);
            end else begin
               list_count--;
            end
         end
         bol_pkg::OP_INSERT: begin
            if (list_count >= ENTRIES) begin
               res.status = bol_pkg::ST_FULL;
            end else if (list_count == 0) begin
               list_entries[0] = value;
               list_count      = 1;
            end else if (int'(pos) >= list_count) begin
               res.status = bol_pkg::ST_BADPOS;
            end else begin
               open_gap(int'(pos) + 1);
               list_entries[int'(pos) + 1] = value;
            end
         end
         bol_pkg::OP_DEL_VALUE: begin
            if (list_count == 0) begin
               res.status = bol_pkg::ST_EMPTY;
            end else begin
               for (int k = list_count - 1; k >= 0; k--) begin
                  if (list_entries[k] == value) hit = k;
               end
               if (hit < 0) res.status = bol_pkg::ST_NOTFOUND;
               else close_gap(hit);
            end
         end
         bol_pkg::OP_DEL_POS: begin
            if (list_count == 0) begin
               res.status = bol_pkg::ST_EMPTY;
            end else if (pos == 0 || int'(pos) > list_count) begin
               res.status = bol_pkg::ST_BADPOS;
            end else begin
               close_gap(int'(pos) - 1);
            end
         end
         default: begin
            if (list_count == 0) begin
               res.status = bol_pkg::ST_EMPTY;
            end else if (int'(pos) >= list_count) begin
               res.status = bol_pkg::ST_BADPOS;
            end else begin
               res.read_value = list_entries[pos];
            end
         end
      endcase
      res.head_value = (list_count != 0) ? list_entries[0] : '0;
      res.tail_value = (list_count != 0) ? list_entries[list_count-1] : '0;
      res.size       = bol_pkg::size_type'(list_count);
      return res;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      list_result_type got;
      if (reset) begin
         list_count = 0;
         expected_results.delete();
         mismatch_count <= 0;
         pending_count  <= 0;
         result_index   = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status     = rsp_mon.status;
            got.read_value = rsp_mon.read_value;
            got.head_value = rsp_mon.head_value;
            got.tail_value = rsp_mon.tail_value;
            got.size       = rsp_mon.size;
            if (expected_results.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("checker: result %0d arrived with no request outstanding",
                           result_index);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (got.status != want.status || got.read_value != want.read_value ||
                   got.head_value != want.head_value || got.tail_value != want.tail_value ||
                   got.size != want.size) begin
                  if (mismatch_count < 10) begin
                     $display({"checker: result %0d expected status=%0d read=%02h head=%02h",
                               " tail=%02h size=%0d, got status=%0d read=%02h head=%02h",
                               " tail=%02h size=%0d"}, result_index,
                              want.status, want.read_value, want.head_value,
                              want.tail_value, want.size, got.status, got.read_value,
                              got.head_value, got.tail_value, got.size);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
            result_index++;
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_results.insert(expected_results.size(),
                                    apply_request(req_mon.op, req_mon.value,
                                                  req_mon.position));
         end
         pending_count <= expected_results.size();
      end
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int ENTRIES      = 32;
   localparam int VALUE_W      = 8;
   localparam int RANDOM_ITEMS = 600;
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 4 * ENTRIES + 16;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   int   cycle_count;
   bit   calm;
   bit   sender_may_idle;
   bit   hold_request;
   bit   hold_done;

   bol_req_if req_if ();
   bol_rsp_if rsp_if ();

   bounded_ordered_list #(
      .ENTRIES(ENTRIES),
      .VALUE_W(VALUE_W)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if)
   );

   list_result_checker #(
      .ENTRIES(ENTRIES)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic send_request(input bol_pkg::op_type op, input bol_pkg::val_type value,
                               input bol_pkg::pos_type pos);
      if (sender_may_idle && !calm && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.op       <= op;
      req_if.value    <= value;
      req_if.position <= pos;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Mode 0 grows the list toward full, mode 2 drains it toward empty.
   function automatic bol_pkg::op_type pick_op(input int mode);
      int r;
      r = $urandom_range(0, 99);
      if (mode == 0) begin
         if (r < 30) return bol_pkg::OP_ADD_BACK;
         if (r < 55) return bol_pkg::OP_ADD_FRONT;
         if (r < 80) return bol_pkg::OP_INSERT;
         if (r < 88) return bol_pkg::OP_READ;
      end else if (mode == 2) begin
         if (r < 25) return bol_pkg::OP_TAKE_FRONT;
         if (r < 45) return bol_pkg::OP_TAKE_BACK;
         if (r < 65) return bol_pkg::OP_DEL_VALUE;
         if (r < 85) return bol_pkg::OP_DEL_POS;
         if (r < 92) return bol_pkg::OP_READ;
      end
      return bol_pkg::op_type'($urandom_range(0, 7));
   endfunction

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      int hold_count;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_if.ready <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      bol_pkg::op_type  op;
      bol_pkg::val_type value;
      bol_pkg::pos_type pos;
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.op       <= bol_pkg::OP_ADD_BACK;
      req_if.value    <= '0;
      req_if.position <= '0;
      calm            = 1'b0;
      sender_may_idle = 1'b1;
      hold_request    = 1'b0;
      hold_done       = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Each removal, the read and an insert against an empty list, then the edges of each position check.
      send_request(bol_pkg::OP_TAKE_FRONT, 8'h00, 6'd0);
      send_request(bol_pkg::OP_TAKE_BACK,  8'h00, 6'd0);
      send_request(bol_pkg::OP_DEL_VALUE,  8'h00, 6'd0);
      send_request(bol_pkg::OP_DEL_POS,    8'h00, 6'd1);
      send_request(bol_pkg::OP_READ,       8'h00, 6'd0);
      send_request(bol_pkg::OP_INSERT,     8'hAA, 6'd63);
      send_request(bol_pkg::OP_ADD_BACK,   8'hFF, 6'd0);
      send_request(bol_pkg::OP_ADD_FRONT,  8'h00, 6'd0);
      send_request(bol_pkg::OP_INSERT,     8'h55, 6'd0);
      send_request(bol_pkg::OP_INSERT,     8'h11, 6'd4);
      send_request(bol_pkg::OP_INSERT,     8'h11, 6'd63);
      send_request(bol_pkg::OP_READ,       8'h00, 6'd0);
      send_request(bol_pkg::OP_READ,       8'h00, 6'd3);
      send_request(bol_pkg::OP_READ,       8'h00, 6'd4);
      send_request(bol_pkg::OP_READ,       8'hFF, 6'd63);
      send_request(bol_pkg::OP_DEL_POS,    8'h00, 6'd0);
      send_request(bol_pkg::OP_DEL_POS,    8'h00, 6'd5);
      send_request(bol_pkg::OP_DEL_POS,    8'h00, 6'd63);
      send_request(bol_pkg::OP_DEL_VALUE,  8'h77, 6'd0);
      send_request(bol_pkg::OP_DEL_VALUE,  8'hAA, 6'd0);
      send_request(bol_pkg::OP_DEL_POS,    8'h00, 6'd3);
      send_request(bol_pkg::OP_DEL_POS,    8'h00, 6'd1);
      send_request(bol_pkg::OP_TAKE_FRONT, 8'h00, 6'd0);
      send_request(bol_pkg::OP_ADD_BACK,   8'h5A, 6'd0);
      send_request(bol_pkg::OP_TAKE_BACK,  8'h00, 6'd0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 200) hold_request = 1'b1;
         if (i == RANDOM_ITEMS - 100) calm = 1'b1;
         sender_may_idle = ((i / 40) % 4) != 3;
         op    = pick_op((i / 50) % 3);
         value = $urandom_range(0, 1) ? bol_pkg::val_type'($urandom_range(0, 15))
                                      : bol_pkg::val_type'($urandom_range(0, 255));
         pos   = ($urandom_range(0, 4) != 0) ? bol_pkg::pos_type'($urandom_range(0, 33))
                                             : bol_pkg::pos_type'($urandom_range(0, 63));
         send_request(op, value, pos);
      end
      req_if.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
